FILE: rtl/core/lxrr_pkg.sv
// lxrr_pkg: shared types, constants and register map of the crossbar core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lxrr_pkg;
	localparam int MAX_NODES   = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_WIDTH   = 32;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = NODE_W + PTR_W;
	localparam int STORE_SIZE  = MAX_NODES * QUEUE_DEPTH;
	localparam int MOVED_W     = $clog2(MAX_NODES + 1);

	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_POP  = 2'd2;
	localparam logic [1:0] FUNC_NOP  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [0:0] REG_LATENCY   = 1'd0;
	localparam logic [0:0] REG_NUM_NODES = 1'd1;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  src_port;
		logic [2:0]  dest_node;
		logic [31:0] payload_tag;
		logic [2:0]  pop_node;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_tag;
		logic [3:0]  moved_count;
		logic        out_now_empty;
	} out_item_t;

	// commands from controller to datapath
	typedef struct packed {
		logic           load;      // capture item
		logic           rd_push;   // read last entry of source queue
		logic           do_push;   // write pushed entry
		logic           rd_head;   // read head of scanned source
		logic           do_move;   // evaluate and move scanned head
		logic           scan_next; // advance scan index
		logic           tick_end;  // rotate start, bump cycle count
		logic           rd_pop;    // read output head
		logic           do_pop;    // pop output head
		logic           emit;      // present result
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       scan_last;
	} stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/latency_crossbar_round_robin_core.sv
// latency_crossbar_round_robin_core: top level of the fixed-latency crossbar
// depends on lxrr_pkg, lxrr_ctrl, lxrr_dp
//
// usage: raise start with an item on in_item while busy is low; the item
// is taken at that edge and busy stays high until its result is shown.
// one result per item appears on out_item for one cycle with done high;
// the receiver cannot stall, so it must take it in that cycle.
// push and pop pass through decode, which issues the read, and a write state
// before done, a no-op goes from decode straight to done; a tick scans the n source
// nodes in use one at a time through the single store read port, reading
// each head and then moving it.
// busy falls as done rises, so the next item can be taken at the edge that
// ends the done cycle.
// registers over apb: latency at 0x0, num_nodes at 0x4; write only while
// busy is low. reset clears queue pointers, rotate index and cycle count and
// sets the registers (num_nodes to 8); packet stores hold no reset value
// and no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none
module latency_crossbar_round_robin_core import lxrr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  in_item_t         in_item,
	output out_item_t        out_item,
	output logic             done,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	cmd_t  cmd;
	stat_t stat;
	logic [15:0] latency_q;
	logic [3:0]  num_nodes_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latency_q   <= 16'd1;
			num_nodes_q <= 4'd8;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_LATENCY) latency_q <= pwdata[15:0];
			else num_nodes_q <= pwdata[3:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_LATENCY) prdata = {16'd0, latency_q};
			else if (paddr[2] == REG_NUM_NODES) prdata = {28'd0, num_nodes_q};
		end
	end

	lxrr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
	);

	lxrr_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_item(in_item),
		.latency(latency_q), .num_nodes(num_nodes_q), .out_item(out_item), .done(done)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not raise busy");
	a_moved_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_item.moved_count != 4'd0) |-> out_item.status == ST_OK)
		else $error("moved count with error status");
	a_pop_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_item.status != ST_OK) |-> out_item.read_tag == 32'd0)
		else $error("tag on failed op");
endmodule
`default_nettype wire

FILE: rtl/core/lxrr_ctrl.sv
// lxrr_ctrl: sequencer for push, tick scan and pop
// depends on lxrr_pkg
`timescale 1ns / 1ps
`default_nettype none
module lxrr_ctrl import lxrr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  stat_t      stat,
	output cmd_t       cmd
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DEC  = 7'b0000010,
		S_PUSH = 7'b0000100,
		S_RDH  = 7'b0001000,
		S_MOVE = 7'b0010000,
		S_POP  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = S_DEC;
				end
			end
			S_DEC: begin
				case (stat.func)
					FUNC_PUSH: begin
						cmd.rd_push = 1'b1;
						state_nx = S_PUSH;
					end
					FUNC_TICK: begin
						cmd.rd_head = 1'b1;
						state_nx = S_MOVE;
					end
					FUNC_POP: begin
						cmd.rd_pop = 1'b1;
						state_nx = S_POP;
					end
					default: state_nx = S_DONE;
				endcase
			end
			S_PUSH: begin
				cmd.do_push = 1'b1;
				state_nx = S_DONE;
			end
			S_RDH: begin
				cmd.rd_head = 1'b1;
				state_nx = S_MOVE;
			end
			S_MOVE: begin
				cmd.do_move = 1'b1;
				if (stat.scan_last) begin
					cmd.tick_end = 1'b1;
					state_nx = S_DONE;
				end else begin
					cmd.scan_next = 1'b1;
					state_nx = S_RDH;
				end
			end
			S_POP: begin
				cmd.do_pop = 1'b1;
				state_nx = S_DONE;
			end
			S_DONE: begin
				cmd.emit = 1'b1;
				state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/core/lxrr_dp.sv
// lxrr_dp: queue pointers, packet stores and result register
// depends on lxrr_pkg
`timescale 1ns / 1ps
`default_nettype none
module lxrr_dp import lxrr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  cmd_t            cmd,
	output stat_t           stat,
	input  in_item_t        in_item,
	input  wire logic [15:0] latency,
	input  wire logic [3:0]  num_nodes,
	output out_item_t       out_item,
	output logic            done
);
	logic [TAG_WIDTH-1:0] in_tag_mem [STORE_SIZE];
	logic [NODE_W-1:0]    in_dest_mem [STORE_SIZE];
	logic [31:0]          in_ready_mem [STORE_SIZE];
	logic [TAG_WIDTH-1:0] out_tag_mem [STORE_SIZE];

	logic [PTR_W-1:0] in_head_q [MAX_NODES];
	logic [CNT_W-1:0] in_cnt_q [MAX_NODES];
	logic [PTR_W-1:0] out_head_q [MAX_NODES];
	logic [CNT_W-1:0] out_cnt_q [MAX_NODES];
	logic [NODE_W-1:0] rot_q;
	logic [31:0] cycle_q;
	logic [MAX_NODES-1:0] taken_q;

	in_item_t item_q;
	logic [NODE_W:0] n_q;
	logic [NODE_W-1:0] scan_q;
	logic [NODE_W:0] step_q;
	logic [MOVED_W-1:0] moved_q;

	logic [TAG_WIDTH-1:0] rd_tag_q, rd_otag_q;
	logic [NODE_W-1:0]    rd_dest_q;
	logic [31:0]          rd_ready_q;

	logic [1:0] status_q;
	logic [31:0] rtag_q;
	logic nowempty_q;
	logic done_q;

	logic [NODE_W-1:0] src, dst, pn;
	logic [4:0] n_eff;
	logic [NODE_W:0] n;
	logic [CNT_W-1:0] sc_cnt, dcnt;
	logic move_ok;
	logic [NODE_W:0] rot_start_full, scan_nx_full;
	logic [2*NODE_W:0] rot_rem;

	assign src = item_q.src_port[NODE_W-1:0];
	assign dst = item_q.dest_node[NODE_W-1:0];
	assign pn  = item_q.pop_node[NODE_W-1:0];

	always_comb begin
		n_eff = {1'b0, num_nodes};
		if (num_nodes == 4'd0) n_eff = 5'd1;
		else if ({1'b0, num_nodes} > 5'(MAX_NODES)) n_eff = 5'(MAX_NODES);
		n = n_eff[NODE_W:0];
	end

	// start of scan is rotate index modulo n, by restoring compare and subtract
	always_comb begin
		rot_rem = (2*NODE_W+1)'(rot_q);
		for (int k = NODE_W - 1; k >= 0; k--) begin
			if (rot_rem >= ((2*NODE_W+1)'(n) << k))
				rot_rem = rot_rem - ((2*NODE_W+1)'(n) << k);
		end
		rot_start_full = rot_rem[NODE_W:0];
	end

	assign scan_nx_full = ({1'b0, scan_q} + 1'b1 >= n_q) ? '0 : ({1'b0, scan_q} + 1'b1);

	assign sc_cnt = in_cnt_q[scan_q];
	assign dcnt   = out_cnt_q[rd_dest_q];
	assign move_ok = (sc_cnt != '0) && (rd_ready_q <= cycle_q)
		&& ({1'b0, rd_dest_q} < n_q) && !taken_q[rd_dest_q]
		&& (dcnt != CNT_W'(QUEUE_DEPTH));

	assign stat.func = item_q.func;
	assign stat.scan_last = (step_q + 1'b1 >= n_q);

	// memory reads
	always_ff @(posedge clk) begin
		if (cmd.rd_push) begin
			rd_ready_q <= in_ready_mem[{src, PTR_W'(in_head_q[src] + in_cnt_q[src][PTR_W-1:0]
				- 1'b1)}];
		end else if (cmd.rd_head) begin
			rd_ready_q <= in_ready_mem[{scan_q, in_head_q[scan_q]}];
		end
		if (cmd.rd_head) begin
			rd_tag_q  <= in_tag_mem[{scan_q, in_head_q[scan_q]}];
			rd_dest_q <= in_dest_mem[{scan_q, in_head_q[scan_q]}];
		end
		if (cmd.rd_pop) begin
			rd_otag_q <= out_tag_mem[{pn, out_head_q[pn]}];
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (cmd.do_push && status_q == ST_OK) begin
			in_tag_mem[{src, PTR_W'(in_head_q[src] + in_cnt_q[src][PTR_W-1:0])}] <=
				item_q.payload_tag[TAG_WIDTH-1:0];
			in_dest_mem[{src, PTR_W'(in_head_q[src] + in_cnt_q[src][PTR_W-1:0])}] <= dst;
			in_ready_mem[{src, PTR_W'(in_head_q[src] + in_cnt_q[src][PTR_W-1:0])}] <=
				(in_cnt_q[src] == '0) ? (cycle_q + {16'd0, latency}) : (rd_ready_q + 32'd1);
		end
		if (cmd.do_move && move_ok) begin
			out_tag_mem[{rd_dest_q, PTR_W'(out_head_q[rd_dest_q]
				+ out_cnt_q[rd_dest_q][PTR_W-1:0])}] <= rd_tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				in_head_q[i]  <= '0;
				in_cnt_q[i]   <= '0;
				out_head_q[i] <= '0;
				out_cnt_q[i]  <= '0;
			end
			rot_q    <= '0;
			cycle_q  <= '0;
			taken_q  <= '0;
			scan_q   <= '0;
			step_q   <= '0;
			moved_q  <= '0;
			n_q      <= '0;
			status_q <= ST_OK;
			rtag_q   <= '0;
			nowempty_q <= 1'b0;
			done_q   <= 1'b0;
			item_q   <= '0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.load) begin
				item_q  <= in_item;
				n_q     <= n;
				taken_q <= '0;
				moved_q <= '0;
				step_q  <= '0;
				scan_q  <= rot_start_full[NODE_W-1:0];
				rtag_q  <= '0;
				nowempty_q <= 1'b0;
				status_q <= ST_OK;
				case (in_item.func)
					FUNC_PUSH: begin
						if ({1'b0, in_item.src_port} >= n
							|| {1'b0, in_item.dest_node} >= n) begin
							status_q <= ST_RANGE;
						end else if (in_cnt_q[in_item.src_port[NODE_W-1:0]]
							== CNT_W'(QUEUE_DEPTH)) begin
							status_q <= ST_FULL;
						end
					end
					FUNC_POP: begin
						if ({1'b0, in_item.pop_node} >= n) begin
							status_q <= ST_RANGE;
						end else if (out_cnt_q[in_item.pop_node[NODE_W-1:0]] == '0) begin
							status_q <= ST_EMPTY;
							nowempty_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.do_push && status_q == ST_OK) begin
				in_cnt_q[src] <= in_cnt_q[src] + 1'b1;
			end
			if (cmd.do_move && move_ok) begin
				out_cnt_q[rd_dest_q] <= out_cnt_q[rd_dest_q] + 1'b1;
				in_head_q[scan_q] <= in_head_q[scan_q] + 1'b1;
				in_cnt_q[scan_q]  <= in_cnt_q[scan_q] - 1'b1;
				taken_q[rd_dest_q] <= 1'b1;
				moved_q <= moved_q + 1'b1;
			end
			if (cmd.scan_next) begin
				scan_q <= scan_nx_full[NODE_W-1:0];
				step_q <= step_q + 1'b1;
			end
			if (cmd.tick_end) begin
				rot_q   <= NODE_W'(({1'b0, rot_start_full[NODE_W-1:0]} + 1'b1 >= n_q) ? '0
					: ({1'b0, rot_start_full[NODE_W-1:0]} + 1'b1));
				cycle_q <= cycle_q + 32'd1;
			end
			if (cmd.do_pop && status_q == ST_OK) begin
				rtag_q <= 32'(rd_otag_q);
				out_head_q[pn] <= out_head_q[pn] + 1'b1;
				out_cnt_q[pn]  <= out_cnt_q[pn] - 1'b1;
				nowempty_q <= (out_cnt_q[pn] == CNT_W'(1));
			end
		end
	end

	assign done = done_q;
	assign out_item.status = status_q;
	assign out_item.read_tag = rtag_q;
	assign out_item.moved_count = 4'(moved_q);
	assign out_item.out_now_empty = nowempty_q;
endmodule
`default_nettype wire
